@@ hdl/tdt_pkg.sv @@
// ----------------------------------------------------------------------------
// tdt_pkg: shared types and constants for the turn-drive-turn sequencer
// Word widths, operation codes, controller/datapath command and status.
// ----------------------------------------------------------------------------
package tdt_pkg;

  localparam int WordBits   = 24;
  localparam int FracBits   = 16;
  localparam int CordicSteps = 16;
  localparam int RegBits    = WordBits - 1;
  localparam int CfgIdxBits = 3;
  localparam int StepBits   = 5;

  typedef logic signed [WordBits-1:0] word_t;
  typedef logic [RegBits-1:0]         ureg_t;

  localparam logic [1:0] OP_POSE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_GOAL = 2'd2;

  localparam logic [CfgIdxBits-1:0] REG_MAX_LIN  = 3'd0;
  localparam logic [CfgIdxBits-1:0] REG_MAX_ANG  = 3'd1;
  localparam logic [CfgIdxBits-1:0] REG_TOL      = 3'd2;
  localparam logic [CfgIdxBits-1:0] REG_LIN_RAMP = 3'd3;
  localparam logic [CfgIdxBits-1:0] REG_ANG_RAMP = 3'd4;

  // pi in Q.FracBits, rounded from Q30
  localparam logic [33:0] PiQ30 = 34'h0C90FDAA2;
  localparam word_t PI_Q = word_t'((PiQ30 + (34'd1 << (29 - FracBits))) >> (30 - FracBits));

  function automatic word_t atan_entry(input logic [StepBits-1:0] i);
    logic [33:0] t;
    begin
      case (i)
        5'd0:  t = 34'h03243F6A8;
        5'd1:  t = 34'h01DAC6705;
        5'd2:  t = 34'h00FADBAFC;
        5'd3:  t = 34'h007F56EA6;
        5'd4:  t = 34'h003FEAB76;
        5'd5:  t = 34'h001FFD55B;
        5'd6:  t = 34'h000FFFAAA;
        5'd7:  t = 34'h0007FFF55;
        5'd8:  t = 34'h0003FFFEA;
        5'd9:  t = 34'h0001FFFFD;
        5'd10: t = 34'h0000FFFFF;
        5'd11: t = 34'h00007FFFF;
        5'd12: t = 34'h00003FFFF;
        5'd13: t = 34'h00001FFFF;
        5'd14: t = 34'h00000FFFF;
        5'd15: t = 34'h000007FFF;
        5'd16: t = 34'h000003FFF;
        5'd17: t = 34'h000001FFF;
        5'd18: t = 34'h000000FFF;
        5'd19: t = 34'h0000007FF;
        5'd20: t = 34'h0000003FF;
        5'd21: t = 34'h0000001FF;
        5'd22: t = 34'h0000000FF;
        5'd23: t = 34'h00000007F;
        default: t = '0;
      endcase
      atan_entry = word_t'((t + (34'd1 << (29 - FracBits))) >> (30 - FracBits));
    end
  endfunction

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NONE    = 4'd0,
    CMD_POSE    = 4'd1,
    CMD_GOAL    = 4'd2,
    CMD_CORDIC  = 4'd3,
    CMD_SQRT_G  = 4'd4,   // load sqrt for goal segment
    CMD_SQRT_T  = 4'd5,   // load sqrt for tick distance
    CMD_SQ_STEP = 4'd6,
    CMD_SEG     = 4'd7,   // store segment length
    CMD_DECIDE  = 4'd8,   // tick: pick phase, set up ramp
    CMD_DIV     = 4'd9,
    CMD_FINISH  = 4'd10
  } cmd_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [StepBits-1:0] step;
  } dp_ctl_t;

  typedef struct packed {
    logic sq_overflow;   // sum of squares overflowed (never set by the datapath)
    logic need_div;      // ramp needs a division
  } dp_sts_t;

endpackage

@@ hdl/tdt_datapath.sv @@
// ----------------------------------------------------------------------------
// tdt_datapath: pose/goal state, CORDIC, square root and ramp divider
// Each unit does one step per cycle under controller command.
// ----------------------------------------------------------------------------
module tdt_datapath (
  input  logic             clk,
  input  logic             rst,
  input  tdt_pkg::dp_ctl_t ctl,
  output tdt_pkg::dp_sts_t sts,
  input  tdt_pkg::word_t   in_x,
  input  tdt_pkg::word_t   in_y,
  input  tdt_pkg::word_t   in_h,
  input  logic             cfg_we,
  input  logic [tdt_pkg::CfgIdxBits-1:0] cfg_idx,
  input  tdt_pkg::ureg_t   cfg_data,
  output tdt_pkg::word_t   res_v,
  output tdt_pkg::word_t   res_w,
  output logic             res_reached,
  output logic             res_active
);
  import tdt_pkg::*;

  localparam int SqBits = 2 * WordBits + 2;

  ureg_t max_lin, max_ang, tol, lin_ramp, ang_ramp;
  word_t cur_x, cur_y, cur_h, st_x, st_y, st_h, tg_x, tg_y, tg_h;
  word_t bearing, seg_len, h_final;
  logic  ft_done, dr_done, fn_done, active;

  // CORDIC
  logic signed [WordBits+2:0] cx, cy, cz;
  // sqrt
  logic [SqBits-1:0] sq_n, sq_res, sq_bit;
  // ramp / divide
  logic [2*RegBits-1:0] dv_rem;
  ureg_t dv_q, dv_den, dv_cap;
  logic  dv_neg, dv_is_w;
  logic  reached;

  function automatic logic [WordBits:0] uabs(input logic signed [WordBits:0] v);
    uabs = v[WordBits] ? -v : v;
  endfunction

  function automatic logic is_near(input word_t a, input word_t b, input ureg_t t);
    logic [WordBits:0] d;
    begin
      d = uabs({a[WordBits-1], a} - {b[WordBits-1], b});
      is_near = d < {2'b00, t};
    end
  endfunction

  // sum of squares of a difference pair
  logic [WordBits:0]   ux, uy;
  logic [SqBits-1:0]   sqx, sqsum;
  word_t pa_x, pa_y, pb_x, pb_y;
  always_comb begin
    if (ctl.cmd == CMD_SQRT_G) begin
      pa_x = st_x; pa_y = st_y; pb_x = tg_x; pb_y = tg_y;
    end else begin
      pa_x = cur_x; pa_y = cur_y; pb_x = st_x; pb_y = st_y;
    end
    ux = uabs({pa_x[WordBits-1], pa_x} - {pb_x[WordBits-1], pb_x});
    uy = uabs({pa_y[WordBits-1], pa_y} - {pb_y[WordBits-1], pb_y});
    sqx = SqBits'(ux) * SqBits'(ux);
    sqsum = sqx + SqBits'(uy) * SqBits'(uy);
  end
  // the sum of two squared 25-bit magnitudes always fits SqBits
  assign sts.sq_overflow = 1'b0;

  // sqrt one step
  logic [SqBits-1:0] sq_trial;
  assign sq_trial = sq_res + sq_bit;
  word_t sq_out;
  assign sq_out = (sq_res > SqBits'(2**RegBits - 1)) ? word_t'(2**RegBits - 1)
                                                     : word_t'(sq_res);

  // ramp setup
  word_t ra, rf, rs;
  ureg_t rramp, rcap;
  logic  use_w, move;
  logic [WordBits:0] r_as, r_fs, r_fa;
  logic  r_full, r_pos;
  word_t d_now;
  assign d_now = sq_out;

  always_comb begin
    ra = cur_h; rf = bearing; rs = st_h; rramp = ang_ramp; rcap = max_ang;
    use_w = 1'b1; move = 1'b0;
    if (!fn_done) begin
      if (!dr_done) begin
        if (!ft_done) begin
          move = !is_near(cur_h, bearing, tol);
        end else begin
          ra = d_now; rf = seg_len; rs = '0; rramp = lin_ramp;
          rcap = max_lin >> 1; use_w = 1'b0;
          move = !is_near(d_now, seg_len, tol);
        end
      end else if (ft_done) begin
        rf = tg_h; rs = h_final;
        move = !is_near(cur_h, tg_h, tol);
      end
    end
    r_as = uabs({ra[WordBits-1], ra} - {rs[WordBits-1], rs});
    r_fs = uabs({rf[WordBits-1], rf} - {rs[WordBits-1], rs});
    r_fa = uabs({rf[WordBits-1], rf} - {ra[WordBits-1], ra});
    r_pos = ($signed({rf[WordBits-1], rf}) - $signed({ra[WordBits-1], ra})) > 0;
    r_full = ({r_as, 1'b0} < {1'b0, r_fs});
  end
  // fa >= ramp already gives the cap, so the divider only sees fa < ramp
  assign sts.need_div = move && !r_full && (rramp != '0) && (r_fa < {2'b00, rramp});

  // restoring divider step on (cap*fa)/ramp, quotient saturates at cap
  logic [2*RegBits:0] dv_trial;
  assign dv_trial = {dv_rem, 1'b0} - {1'b0, dv_den, {(RegBits){1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      max_lin <= 23'd19661; max_ang <= 23'd19661; tol <= 23'd655;
      lin_ramp <= 23'd3277; ang_ramp <= 23'd3277;
      cur_x <= '0; cur_y <= '0; cur_h <= '0; st_x <= '0; st_y <= '0; st_h <= '0;
      tg_x <= '0; tg_y <= '0; tg_h <= '0; bearing <= '0; seg_len <= '0; h_final <= '0;
      ft_done <= 1'b1; dr_done <= 1'b1; fn_done <= 1'b1; active <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_MAX_LIN:  max_lin  <= cfg_data;
          REG_MAX_ANG:  max_ang  <= cfg_data;
          REG_TOL:      tol      <= cfg_data;
          REG_LIN_RAMP: lin_ramp <= cfg_data;
          REG_ANG_RAMP: ang_ramp <= cfg_data;
          default: ;
        endcase
      end
      case (ctl.cmd)
        CMD_POSE: begin
          cur_x <= in_x; cur_y <= in_y; cur_h <= in_h;
        end
        CMD_GOAL: begin
          tg_x <= in_x; tg_y <= in_y; tg_h <= in_h;
          st_x <= cur_x; st_y <= cur_y; st_h <= cur_h;
          ft_done <= 1'b0; dr_done <= 1'b0; fn_done <= 1'b0; active <= 1'b1;
        end
        CMD_SEG: begin
          seg_len <= sq_out;
          bearing <= word_t'(cz);
        end
        CMD_DECIDE: begin
          reached <= active && is_near(cur_x, tg_x, tol) && is_near(cur_y, tg_y, tol)
                     && is_near(cur_h, tg_h, tol);
          if (active && is_near(cur_x, tg_x, tol) && is_near(cur_y, tg_y, tol)
              && is_near(cur_h, tg_h, tol))
            active <= 1'b0;
          if (!fn_done && !move) begin
            if (!dr_done && !ft_done) ft_done <= 1'b1;
            else if (!dr_done) begin
              h_final <= cur_h; dr_done <= 1'b1;
            end else if (ft_done) fn_done <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // unit datapath registers, no reset needed
  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CMD_GOAL: begin
        cx <= (WordBits+3)'(in_x) - (WordBits+3)'(cur_x);
        cy <= (WordBits+3)'(in_y) - (WordBits+3)'(cur_y);
        cz <= '0;
      end
      CMD_CORDIC: begin
        if (ctl.step == '0) begin
          if (cy == '0) begin
            cz <= cx[WordBits+2] ? (WordBits+3)'(PI_Q) : '0;
            cx <= '0; cy <= '0;
          end else if (cx[WordBits+2]) begin
            cx <= -cx; cy <= -cy;
            cz <= cy[WordBits+2] ? -(WordBits+3)'(PI_Q) : (WordBits+3)'(PI_Q);
          end
        end else if (cy != '0 || cx != '0) begin
          if (cy > 0) begin
            cx <= cx + (cy >>> (ctl.step - 1'b1));
            cy <= cy - (cx >>> (ctl.step - 1'b1));
            cz <= cz + (WordBits+3)'(atan_entry(ctl.step - 1'b1));
          end else begin
            cx <= cx - (cy >>> (ctl.step - 1'b1));
            cy <= cy + (cx >>> (ctl.step - 1'b1));
            cz <= cz - (WordBits+3)'(atan_entry(ctl.step - 1'b1));
          end
        end
      end
      CMD_SQRT_G, CMD_SQRT_T: begin
        sq_n <= sqsum; sq_res <= '0;
        sq_bit <= SqBits'(1) << (SqBits - 2);
      end
      CMD_SQ_STEP: begin
        if (sq_bit != '0) begin
          if (sq_n >= sq_trial) begin
            sq_n <= sq_n - sq_trial;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end
      end
      CMD_DECIDE: begin
        dv_is_w <= use_w; dv_neg <= !r_pos; dv_cap <= rcap; dv_den <= rramp;
        dv_rem <= (2*RegBits)'(rcap) * (2*RegBits)'(r_fa);
        if (!move) dv_q <= '0;
        else if (r_full) dv_q <= rcap;
        else if (rramp == '0) dv_q <= (r_fa == '0) ? '0 : rcap;
        else if (r_fa >= {2'b00, rramp}) dv_q <= rcap;
        else dv_q <= '0;
      end
      CMD_DIV: begin
        // fa < ramp keeps the quotient below cap
        if (!dv_trial[2*RegBits]) begin
          dv_rem <= dv_trial[2*RegBits-1:0];
          dv_q   <= {dv_q[RegBits-2:0], 1'b1};
        end else begin
          dv_rem <= {dv_rem[2*RegBits-2:0], 1'b0};
          dv_q   <= {dv_q[RegBits-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // guard: flags a quotient bit shifted out of the top
  logic dv_ovf;
  always_ff @(posedge clk) begin
    if (ctl.cmd == CMD_DECIDE) dv_ovf <= 1'b0;
    else if (ctl.cmd == CMD_DIV && dv_q[RegBits-1]) dv_ovf <= 1'b1;
  end

  ureg_t spd;
  word_t spd_s;
  assign spd = (dv_ovf || dv_q > dv_cap) ? dv_cap : dv_q;
  assign spd_s = dv_neg ? -word_t'(spd) : word_t'(spd);
  assign res_v = dv_is_w ? '0 : spd_s;
  assign res_w = dv_is_w ? spd_s : '0;
  assign res_reached = reached;
  assign res_active = active;

endmodule

@@ hdl/tdt_ctrl.sv @@
// ----------------------------------------------------------------------------
// tdt_ctrl: sequencing state machine and output valid flag
// Steps the datapath units and flags the result word held for the consumer.
// ----------------------------------------------------------------------------
module tdt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_op,
  output tdt_pkg::dp_ctl_t ctl,
  input  tdt_pkg::dp_sts_t sts,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_load
);
  import tdt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CORDIC = 6'b000010,
    S_SQRT   = 6'b000100,
    S_SEG    = 6'b001000,
    S_DIV    = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  localparam int SqSteps = WordBits + 1;
  localparam int DivSteps = RegBits;

  state_t state, state_next;
  logic [StepBits-1:0] step, step_next;
  logic tick, tick_next;
  logic accept;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    step_next = step + 1'b1;
    tick_next = tick;
    ctl.cmd = CMD_NONE;
    ctl.step = step;
    out_load = 1'b0;
    case (state)
      S_IDLE: begin
        step_next = '0;
        if (accept) begin
          case (in_op)
            OP_POSE: ctl.cmd = CMD_POSE;
            OP_GOAL: begin
              ctl.cmd = CMD_GOAL; state_next = S_CORDIC; tick_next = 1'b0;
            end
            OP_TICK: begin
              ctl.cmd = CMD_SQRT_T; state_next = S_SQRT; tick_next = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_CORDIC: begin
        // step 0 is the quadrant setup, steps 1..CordicSteps the rotations
        ctl.cmd = CMD_CORDIC;
        if (step == StepBits'(CordicSteps + 1)) begin
          state_next = S_SQRT; step_next = '0;
          ctl.cmd = CMD_SQRT_G;
        end
      end
      S_SQRT: begin
        ctl.cmd = CMD_SQ_STEP;
        if (step == StepBits'(SqSteps - 1)) begin
          state_next = S_SEG; step_next = '0;
        end
      end
      S_SEG: begin
        step_next = '0;
        if (tick) begin
          ctl.cmd = CMD_DECIDE;
          state_next = sts.need_div ? S_DIV : S_OUT;
        end else begin
          ctl.cmd = CMD_SEG; state_next = S_IDLE;
        end
      end
      S_DIV: begin
        ctl.cmd = CMD_DIV;
        if (step == StepBits'(DivSteps - 1)) state_next = S_OUT;
      end
      S_OUT: begin
        out_load = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; step <= '0; tick <= 1'b0; out_valid <= 1'b0;
    end else begin
      state <= state_next; step <= step_next; tick <= tick_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

@@ hdl/turn_drive_turn_motion_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// turn_drive_turn_motion_sequencer_top: point-to-point motion sequencer
// Pose update, new goal and control tick words in; velocity words out.
// ----------------------------------------------------------------------------
// Sequence: a pose update is stored when taken; a new goal runs the CORDIC,
//   then the segment square root, then stores both; a control tick runs the
//   distance square root, the decision, the divider (23 steps) if needed, the load.
// Throughput: one word at a time; the next word is taken once the previous
//   one is done and its result word has left the output register.
// Reset (rst, synchronous): registers to defaults, phases done, no goal active.
// ----------------------------------------------------------------------------
module turn_drive_turn_motion_sequencer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    operation,
  input  tdt_pkg::word_t                pos_x,
  input  tdt_pkg::word_t                pos_y,
  input  tdt_pkg::word_t                heading,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tdt_pkg::word_t                linear_velocity,
  output tdt_pkg::word_t                angular_velocity,
  output logic                          goal_reached,
  output logic                          goal_active,
  input  logic                          cfg_we,
  input  logic [tdt_pkg::CfgIdxBits-1:0] cfg_index,
  input  tdt_pkg::ureg_t                cfg_data
);
  import tdt_pkg::*;

  dp_ctl_t ctl;
  dp_sts_t sts;
  logic    out_load;
  word_t   res_v, res_w;
  logic    res_reached, res_active;

  tdt_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .in_op(operation),
    .ctl, .sts, .out_valid, .out_ready, .out_load
  );

  tdt_datapath u_dp (
    .clk, .rst, .ctl, .sts,
    .in_x(pos_x), .in_y(pos_y), .in_h(heading),
    .cfg_we, .cfg_idx(cfg_index), .cfg_data,
    .res_v, .res_w, .res_reached, .res_active
  );

  // output word register, held until taken
  always_ff @(posedge clk) begin
    if (out_load) begin
      linear_velocity  <= res_v;
      angular_velocity <= res_w;
      goal_reached     <= res_reached;
      goal_active      <= res_active;
    end
  end

endmodule

@@ hdl/tdt_checker.sv @@
// ----------------------------------------------------------------------------
// tdt_checker: port-level checks on the sequencer
// Output word stability and reached/active consistency.
// ----------------------------------------------------------------------------
module tdt_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic goal_reached,
  input logic goal_active
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(goal_reached) && $stable(goal_active))
    else $error("output word changed while stalled");
  a_reach_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && goal_reached |-> !goal_active)
    else $error("goal still active after reached");
  a_no_take_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result pending");
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");
endmodule

bind turn_drive_turn_motion_sequencer_top tdt_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .goal_reached, .goal_active
);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for the turn-drive-turn motion sequencer
// Drives pose, goal and tick words with random gaps and output stalls,
// predicts every velocity word in a local model and checks it field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import tdt_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] operation = OP_POSE;
  word_t pos_x = '0, pos_y = '0, heading = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  word_t linear_velocity, angular_velocity;
  logic goal_reached, goal_active;
  logic cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index = '0;
  ureg_t cfg_data = '0;

  always #5 clk = ~clk;

  turn_drive_turn_motion_sequencer_top dut (.*);

  // expected velocity word
  typedef struct packed {
    word_t lin;
    word_t ang;
    logic  reached;
    logic  act;
  } cmd_word_t;

  cmd_word_t cmd_q[$];
  int n_errors = 0;
  bit hold_off = 0;     // long receiver stall request
  bit bursty = 1;       // sender gaps on/off

  // ---- predictor state ----
  longint unsigned lin_max, ang_max, tol, lin_ramp, ang_ramp;
  longint cur_x, cur_y, cur_h, st_x, st_y, st_h, tg_x, tg_y, tg_h;
  longint brg, seg_len, h_pre_final;
  bit turn1_ok, drive_ok, turn2_ok, pursuing;

  localparam longint SAT_MAX = (64'sd1 <<< (WordBits - 1)) - 1;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint qr30(longint unsigned t);
    return longint'((t + (64'd1 << (29 - FracBits))) >> (30 - FracBits));
  endfunction

  function automatic bit close(longint a, longint b);
    return mag(a - b) < tol;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint span(longint ax, longint ay, longint bx, longint by);
    longint unsigned ux, uy, sx, sum, r;
    ux = mag(ax - bx);
    uy = mag(ay - by);
    sx = ux * ux;
    sum = sx + uy * uy;
    if (sum < sx) return SAT_MAX;
    r = int_sqrt(sum);
    return r > SAT_MAX ? SAT_MAX : longint'(r);
  endfunction

  function automatic longint bearing_of(longint dx, longint dy);
    longint unsigned tab[16] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA,
      64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF,
      64'h0000FFFF, 64'h00007FFF};
    longint x, y, z, xs, ys, pi_q;
    pi_q = qr30(64'hC90FDAA2);
    if (dy == 0) return dx < 0 ? pi_q : 0;
    x = dx; y = dy; z = 0;
    if (x < 0) begin
      x = -x; y = -y;
      z = dy > 0 ? pi_q : -pi_q;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += qr30(tab[i]);
      end else begin
        x -= ys; y += xs; z -= qr30(tab[i]);
      end
    end
    return z;
  endfunction

  function automatic longint ramp(longint a, longint f, longint s,
                                  longint unsigned rl, longint unsigned cap);
    longint unsigned as_, fs, fa, vel;
    as_ = mag(a - s); fs = mag(f - s); fa = mag(f - a);
    if (2 * as_ < fs) vel = cap;
    else if (rl == 0) vel = fa == 0 ? 0 : cap;
    else vel = cap * fa / rl;
    if (vel > cap) vel = cap;
    return (f - a > 0) ? longint'(vel) : -longint'(vel);
  endfunction

  task automatic model_reset();
    lin_max = 19661; ang_max = 19661; tol = 655; lin_ramp = 3277; ang_ramp = 3277;
    {cur_x, cur_y, cur_h, st_x, st_y, st_h, tg_x, tg_y, tg_h} = '0;
    brg = 0; seg_len = 0; h_pre_final = 0;
    turn1_ok = 1; drive_ok = 1; turn2_ok = 1; pursuing = 0;
  endtask

  // advance the model by one accepted word; queue a command word on ticks
  task automatic predict_word(logic [1:0] op, word_t px, word_t py, word_t ph);
    longint v, w, d;
    bit hit;
    cmd_word_t c;
    v = 0; w = 0; hit = 0;
    if (op == OP_POSE) begin
      cur_x = px; cur_y = py; cur_h = ph;
    end else if (op == OP_GOAL) begin
      tg_x = px; tg_y = py; tg_h = ph;
      st_x = cur_x; st_y = cur_y; st_h = cur_h;
      brg = bearing_of(tg_x - st_x, tg_y - st_y);
      seg_len = span(st_x, st_y, tg_x, tg_y);
      turn1_ok = 0; drive_ok = 0; turn2_ok = 0; pursuing = 1;
    end else if (op == OP_TICK) begin
      if (pursuing && close(cur_x, tg_x) && close(cur_y, tg_y) && close(cur_h, tg_h)) begin
        hit = 1; pursuing = 0;
      end
      d = span(cur_x, cur_y, st_x, st_y);
      if (!turn2_ok) begin
        if (!drive_ok) begin
          if (!turn1_ok) begin
            if (!close(cur_h, brg)) w = ramp(cur_h, brg, st_h, ang_ramp, ang_max);
            else turn1_ok = 1;
          end else if (!close(d, seg_len)) begin
            v = ramp(d, seg_len, 0, lin_ramp, lin_max >> 1);
          end else begin
            h_pre_final = cur_h; drive_ok = 1;
          end
        end else if (turn1_ok) begin
          if (!close(cur_h, tg_h)) w = ramp(cur_h, tg_h, h_pre_final, ang_ramp, ang_max);
          else turn2_ok = 1;
        end
      end
      c.lin = word_t'(v); c.ang = word_t'(w);
      c.reached = hit; c.act = pursuing;
      cmd_q.push_back(c);
    end
  endtask

  task automatic report(string what, longint got, longint exp);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
    n_errors++;
  endtask

  // ---- sender: one word, with optional random gap before it ----
  task automatic send(logic [1:0] op, word_t px, word_t py, word_t ph);
    if (bursty && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op; pos_x <= px; pos_y <= py; heading <= ph;
    do @(posedge clk); while (!in_ready);
    predict_word(op, px, py, ph);
  endtask

  // ---- receiver stall pattern: stretches of stalls, stretches of none ----
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(20, 200)) begin
        @(posedge clk);
        if (hold_off) out_ready <= 1'b0;
        else if (mode == 0) out_ready <= 1'b1;
        else out_ready <= ($urandom_range(0, mode * 2) == 0) ? 1'b0 : 1'b1;
      end
    end
  end

  // ---- checker ----
  always @(posedge clk) begin
    cmd_word_t e;
    if (!rst && out_valid && out_ready) begin
      if (cmd_q.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        e = cmd_q.pop_front();
        if (linear_velocity !== e.lin) report("linear_velocity", linear_velocity, e.lin);
        if (angular_velocity !== e.ang) report("angular_velocity", angular_velocity, e.ang);
        if (goal_reached !== e.reached) report("goal_reached", goal_reached, e.reached);
        if (goal_active !== e.act) report("goal_active", goal_active, e.act);
      end
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (cmd_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, ureg_t val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MAX_LIN:  lin_max = val;
      REG_MAX_ANG:  ang_max = val;
      REG_TOL:      tol = val;
      REG_LIN_RAMP: lin_ramp = val;
      REG_ANG_RAMP: ang_ramp = val;
      default: ;
    endcase
  endtask

  function automatic word_t rnd_word();
    case ($urandom_range(0, 3))
      0: return word_t'($urandom);
      1: return word_t'($signed($urandom_range(0, 8'hff)) - 128);
      2: return word_t'($signed($urandom_range(0, 20'hfffff)) - 20'sh80000);
      default: return $urandom_range(0, 1) ? word_t'(24'h7fffff) : word_t'(24'h800000);
    endcase
  endfunction

  // ---- tests ----
  task automatic test_directed();
    word_t ext[4] = '{24'h7fffff, 24'h800000, 24'h000000, 24'hffffff};
    send(OP_TICK, 0, 0, 0);              // tick with no goal
    send(2'd3, 24'h123456, 0, 0);        // unused code, ignored
    send(OP_GOAL, 0, 0, 0);              // zero vector goal
    send(OP_TICK, 0, 0, 0);
    send(OP_GOAL, -24'sd65536, 0, 0);    // horizontal, bearing pi
    send(OP_TICK, 0, 0, 0);
    foreach (ext[i]) begin
      send(OP_POSE, ext[i], ext[(i+1)%4], ext[(i+2)%4]);
      send(OP_GOAL, ext[(i+2)%4], ext[(i+3)%4], ext[i]);
      send(OP_TICK, ext[i], ext[i], ext[i]);
    end
    send(OP_POSE, 0, 0, 0);
    send(OP_GOAL, 0, 0, 0);
    send(OP_TICK, 0, 0, 0);              // reached at once
    send(OP_TICK, 0, 0, 0);
    drain();
  endtask

  // goal then a walk of poses toward it, interleaved with ticks
  task automatic run_goal(int steps);
    word_t gx, gy, gh, cx, cy, ch;
    gx = word_t'($signed($urandom_range(0, 2000)) - 1000);
    gy = word_t'($signed($urandom_range(0, 2000)) - 1000);
    gh = word_t'($signed($urandom_range(0, 400000)) - 200000);
    if ($urandom_range(0, 9) == 0) begin
      gx = rnd_word(); gy = rnd_word(); gh = rnd_word();
    end
    send(OP_GOAL, gx, gy, gh);
    cx = 0; cy = 0; ch = 0;
    for (int s = 0; s < steps; s++) begin
      case ($urandom_range(0, 9))
        0: send(2'd3, rnd_word(), rnd_word(), rnd_word());
        1: send(OP_POSE, rnd_word(), rnd_word(), rnd_word());
        2, 3, 4: begin
          cx = word_t'(cx + (gx - cx) / 2); cy = word_t'(cy + (gy - cy) / 2);
          ch = ($urandom_range(0, 1) ? word_t'(ch + (gh - ch) / 2) : ch);
          if ($urandom_range(0, 3) == 0) begin cx = gx; cy = gy; ch = gh; end
          send(OP_POSE, cx, cy, ch);
        end
        default: send(OP_TICK, rnd_word(), rnd_word(), rnd_word());
      endcase
    end
  endtask

  task automatic test_random(int n_goals);
    for (int g = 0; g < n_goals; g++) run_goal($urandom_range(4, 14));
    drain();
  endtask

  task automatic test_settings();
    write_reg(REG_MAX_LIN, 23'h7fffff);
    write_reg(REG_MAX_ANG, 23'h7fffff);
    write_reg(REG_TOL, '0);
    write_reg(REG_LIN_RAMP, 23'd1);
    write_reg(REG_ANG_RAMP, 23'h7fffff);
    test_random(10);
    write_reg(REG_MAX_LIN, '0);
    write_reg(REG_MAX_ANG, '0);
    write_reg(REG_TOL, 23'h7fffff);
    write_reg(REG_LIN_RAMP, 23'h7fffff);
    write_reg(REG_ANG_RAMP, 23'd1);
    test_random(6);
    write_reg(REG_MAX_LIN, ureg_t'($urandom_range(1000, 60000)));
    write_reg(REG_MAX_ANG, ureg_t'($urandom_range(1000, 60000)));
    write_reg(REG_TOL, ureg_t'($urandom_range(50, 2000)));
    write_reg(REG_LIN_RAMP, ureg_t'($urandom_range(1, 8000)));
    write_reg(REG_ANG_RAMP, ureg_t'($urandom_range(1, 8000)));
    test_random(12);
  endtask

  // receiver holds off while ticks keep coming, so input backs up
  task automatic test_backpressure();
    bursty = 0;
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 8; i++) send(OP_TICK, 0, 0, 0);
    join
    bursty = 1;
    drain();
  endtask

  initial begin
    model_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(20);
    test_backpressure();
    test_settings();
    if (n_errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
